@@ hdl/alid_pkg.sv @@
// alid_pkg: shared types and constants for the array list unit
// used by alid_cell, alid_obuf and array_list_insert_delete_search_unit
// no dependencies

package alid_pkg;

    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int LEN_W   = 6;
    localparam int CHUNK_W = 32;

    // operation codes on the input mode field
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_DELETE = 3'd1;
    localparam logic [2:0] MODE_LOCATE = 3'd2;
    localparam logic [2:0] MODE_CHANGE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // per-cycle action broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_CHG
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
    } cell_ctrl_t;

    typedef struct packed {
        logic              status;
        logic [POS_W-1:0]  found_position;
        logic [LEN_W-1:0]  length;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

    // lowest set bit of a 32-bit chunk, zero when none
    function automatic logic [POS_W-1:0] first_set(input logic [CHUNK_W-1:0] bits);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ hdl/alid_cell.sv @@
// alid_cell: one list entry of the shift chain
// depends on alid_pkg

module alid_cell #(
    parameter int IDX = 0
) (
    input  logic                        aclk,
    input  alid_pkg::cell_ctrl_t        ctrl,
    input  logic [alid_pkg::LEN_W-1:0]  count,
    input  logic [alid_pkg::VAL_W-1:0]  left_value,
    input  logic [alid_pkg::VAL_W-1:0]  right_value,
    output logic [alid_pkg::VAL_W-1:0]  value,
    output logic                        match
);

    logic [alid_pkg::VAL_W-1:0] value_reg;
    logic [alid_pkg::VAL_W-1:0] value_next;
    logic                       above_pos;
    logic                       at_pos;
    logic                       in_list;

    assign above_pos = 32'(IDX) > 32'(ctrl.pos);
    assign at_pos    = 32'(IDX) == 32'(ctrl.pos);
    assign in_list   = 32'(IDX) < 32'(count);

    always_comb begin
        value_next = value_reg;
        case (ctrl.op)
            alid_pkg::CELL_INS: begin
                if (above_pos) begin
                    value_next = left_value;
                end else if (at_pos) begin
                    value_next = ctrl.value;
                end
            end
            alid_pkg::CELL_DEL: begin
                if (above_pos || at_pos) begin
                    value_next = right_value;
                end
            end
            alid_pkg::CELL_CHG: begin
                if (at_pos) begin
                    value_next = ctrl.value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = in_list && (value_reg == ctrl.value);

endmodule

@@ hdl/alid_obuf.sv @@
// alid_obuf: two-slot result buffer driving the m_ channel
// depends on alid_pkg

module alid_obuf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  alid_pkg::push_t             push,
    output logic                        space,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [alid_pkg::POS_W-1:0]  m_found_position,
    output logic [alid_pkg::LEN_W-1:0]  m_length
);

    logic              v0_reg, v0_next;
    logic              v1_reg, v1_next;
    alid_pkg::result_t s0_reg, s0_next;
    alid_pkg::result_t s1_reg, s1_next;
    logic              pop;

    assign pop = v0_reg && m_ready;

    always_comb begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        s0_next = s0_reg;
        s1_next = s1_reg;
        if (pop) begin
            if (v1_reg) begin
                s0_next = s1_reg;
                v1_next = 1'b0;
                if (push.valid) begin
                    s1_next = push.res;
                    v1_next = 1'b1;
                end
            end else if (push.valid) begin
                s0_next = push.res;
            end else begin
                v0_next = 1'b0;
            end
        end else if (push.valid) begin
            if (v0_reg) begin
                s1_next = push.res;
                v1_next = 1'b1;
            end else begin
                s0_next = push.res;
                v0_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
        s0_reg <= s0_next;
        s1_reg <= s1_next;
    end

    assign space            = !v1_reg;
    assign m_valid          = v0_reg;
    assign m_status         = s0_reg.status;
    assign m_found_position = s0_reg.found_position;
    assign m_length         = s0_reg.length;

endmodule

@@ hdl/array_list_insert_delete_search_unit.sv @@
// array_list_insert_delete_search_unit: ordered list of 32-bit values in a chain of cells
// depends on alid_pkg, alid_cell, alid_obuf
//
// usage
//   s_ channel: one beat per operation (mode, position, item_value)
//   m_ channel: one result beat per operation (status, found_position, length)
//   cfg_wr_en / cfg_wr_data: capacity register, write only while the unit is idle
// throughput
//   insert, delete, change, clear and unused codes: a successful insert, delete or
//   change updates the shift chain at the accepting edge, clear resets the count, and
//   the result is registered into the result buffer; one beat per cycle while s_ready
//   is high. locate: the match vector is captured at the accepting edge, then scanned
//   32 cells per cycle, lowest hit first; no new beat taken during the scan
// reset
//   list empties, capacity returns to 32; entry contents stay undefined
// stalls
//   a two-slot result buffer lets one more beat be taken while a result waits;
//   s_ready drops when both slots are occupied and while a locate scan runs

module array_list_insert_delete_search_unit #(
    parameter int DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [alid_pkg::LEN_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_mode,
    input  logic [alid_pkg::POS_W-1:0]         s_position,
    input  logic signed [alid_pkg::VAL_W-1:0]  s_item_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_status,
    output logic [alid_pkg::POS_W-1:0]         m_found_position,
    output logic [alid_pkg::LEN_W-1:0]         m_length
);

    // scan geometry: groups of 32 match bits, padded to a power of two
    localparam int NGRP  = (DEPTH + alid_pkg::CHUNK_W - 1) / alid_pkg::CHUNK_W;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int GRP_N = 2 ** GRP_W;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                                    state_reg, state_next;
    logic [alid_pkg::LEN_W-1:0]                count_reg, count_next;
    logic [alid_pkg::LEN_W-1:0]                cap_reg, cap_next;
    logic [GRP_W-1:0]                          grp_reg, grp_next;
    logic [GRP_N-1:0][alid_pkg::CHUNK_W-1:0]   match_reg, match_next;

    alid_pkg::cell_ctrl_t                      ctrl;
    alid_pkg::push_t                           push;
    logic                                      space;
    logic                                      accept;
    logic [alid_pkg::LEN_W-1:0]                cap_raw;
    logic [alid_pkg::LEN_W-1:0]                cap_eff;
    logic [alid_pkg::LEN_W-1:0]                pos_ext;
    logic                                      full;
    logic                                      ins_ok;
    logic                                      pos_ok;
    logic [alid_pkg::CHUNK_W-1:0]              chunk;
    logic [GRP_N*alid_pkg::CHUNK_W-1:0]        match_flat;

    logic [DEPTH-1:0][alid_pkg::VAL_W-1:0]     cell_value;
    logic [DEPTH-1:0]                          cell_match;

    assign s_ready = (state_reg == ST_IDLE) && space;
    assign accept  = s_valid && s_ready;

    // effective capacity: zero acts as one, clamp to the chain length
    assign cap_raw = (cap_reg == '0) ? alid_pkg::LEN_W'(1) : cap_reg;
    assign cap_eff = (32'(cap_raw) > DEPTH) ? alid_pkg::LEN_W'(DEPTH) : cap_raw;

    assign pos_ext = alid_pkg::LEN_W'(s_position);
    assign full    = count_reg >= cap_eff;
    assign ins_ok  = !full && (pos_ext <= count_reg);
    assign pos_ok  = pos_ext < count_reg;

    // broadcast to the cells; only the op is gated by the handshake
    always_comb begin
        ctrl.pos   = s_position;
        ctrl.value = $unsigned(s_item_value);
        ctrl.op    = alid_pkg::CELL_HOLD;
        if (accept) begin
            unique case (s_mode)
                alid_pkg::MODE_INSERT: ctrl.op = ins_ok ? alid_pkg::CELL_INS : alid_pkg::CELL_HOLD;
                alid_pkg::MODE_DELETE: ctrl.op = pos_ok ? alid_pkg::CELL_DEL : alid_pkg::CELL_HOLD;
                alid_pkg::MODE_CHANGE: ctrl.op = pos_ok ? alid_pkg::CELL_CHG : alid_pkg::CELL_HOLD;
                default:               ctrl.op = alid_pkg::CELL_HOLD;
            endcase
        end
    end

    // the chain: each cell sees its neighbors; the head's left is zero, the tail's right is itself
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [alid_pkg::VAL_W-1:0] left_v;
        logic [alid_pkg::VAL_W-1:0] right_v;

        if (i == 0) begin : g_head
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_value[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_v = cell_value[i];
        end else begin : g_mid_r
            assign right_v = cell_value[i+1];
        end

        alid_cell #(
            .IDX (i)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .match       (cell_match[i])
        );
    end

    // match bits padded out to whole scan groups
    always_comb begin
        match_flat = '0;
        match_flat[DEPTH-1:0] = cell_match;
    end

    assign chunk = match_reg[grp_reg];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        grp_next   = grp_reg;
        match_next = match_reg;

        push.valid              = 1'b0;
        push.res.status         = 1'b1;
        push.res.found_position = '0;
        push.res.length         = count_reg;

        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        alid_pkg::MODE_INSERT: begin
                            push.valid = 1'b1;
                            if (ins_ok) begin
                                count_next      = count_reg + alid_pkg::LEN_W'(1);
                                push.res.status = 1'b0;
                            end
                        end
                        alid_pkg::MODE_DELETE: begin
                            push.valid = 1'b1;
                            if (pos_ok) begin
                                count_next      = count_reg - alid_pkg::LEN_W'(1);
                                push.res.status = 1'b0;
                            end
                        end
                        alid_pkg::MODE_CHANGE: begin
                            push.valid      = 1'b1;
                            push.res.status = !pos_ok;
                        end
                        alid_pkg::MODE_CLEAR: begin
                            push.valid = 1'b1;
                            if (count_reg != '0) begin
                                count_next      = '0;
                                push.res.status = 1'b0;
                            end
                        end
                        alid_pkg::MODE_LOCATE: begin
                            // capture the compare result, scan from group zero
                            match_next = match_flat;
                            grp_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            push.valid = 1'b1;
                        end
                    endcase
                    push.res.length = count_next;
                end
            end
            ST_SCAN: begin
                if (chunk != '0) begin
                    push.valid              = 1'b1;
                    push.res.status         = 1'b0;
                    // position is reported modulo 32, so the group number drops out
                    push.res.found_position = alid_pkg::first_set(chunk);
                    state_next              = ST_IDLE;
                end else if (grp_reg == GRP_W'(NGRP - 1)) begin
                    push.valid = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    grp_next = grp_reg + GRP_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cap_reg   <= alid_pkg::LEN_W'(32);
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
        grp_reg   <= grp_next;
        match_reg <= match_next;
    end

    alid_obuf u_obuf (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .push             (push),
        .space            (space),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_length         (m_length)
    );

endmodule

@@ verif/array_list_insert_delete_search_unit_tb.sv @@
// testbench for array_list_insert_delete_search_unit: queued list operations against a
// behavioral list with its own store, count and capacity
// depends on alid_pkg and the unit's rtl
`timescale 1ns / 1ps

module array_list_insert_delete_search_unit_tb;

    localparam int HALF_PERIOD = 1;
    localparam int LIST_DEPTH  = 32;
    localparam int POOL_SIZE   = 64;
    localparam int PHASES      = 28;
    localparam int PHASE_OPS   = 46;
    localparam int HOLD_PHASE  = 9;    // receiver holds off, sender streams
    localparam int CALM_PHASE  = 1;    // no idling on either side
    localparam int LONG_HOLD   = 200;
    localparam int WDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;

    // codes the unit must refuse
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]                 mode;
        logic [alid_pkg::POS_W-1:0] pos;
        logic [alid_pkg::VAL_W-1:0] value;
    } list_op_t;

    typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} op_mix_t;

    // clock, reset and every unit input start at known values
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [alid_pkg::LEN_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_mode = '0;
    logic [alid_pkg::POS_W-1:0] s_position = '0;
    logic signed [alid_pkg::VAL_W-1:0] s_item_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_status;
    logic [alid_pkg::POS_W-1:0] m_found_position;
    logic [alid_pkg::LEN_W-1:0] m_length;

    always #HALF_PERIOD aclk = ~aclk;

    array_list_insert_delete_search_unit #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_position      (s_position),
        .s_item_value    (s_item_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_position(m_found_position),
        .m_length        (m_length)
    );

    // operations waiting for the driver, results waiting for the unit
    list_op_t          op_queue[$];
    alid_pkg::result_t expected_results[$];

    // behavioral list: written only for positions below list_len
    logic [alid_pkg::VAL_W-1:0] list_mem [LIST_DEPTH];
    int                         list_len = 0;
    logic [alid_pkg::LEN_W-1:0] cap_reg = alid_pkg::LEN_W'(LIST_DEPTH);

    // generator side: tracks only the count, to aim positions inside the list
    int gen_len = 0;
    int gen_lim = LIST_DEPTH;
    logic [alid_pkg::VAL_W-1:0] value_pool [POOL_SIZE];

    // handshake bookkeeping, each counter written by one process only, err_cnt apart
    int in_offered = 0;
    int in_taken = 0;
    int out_taken = 0;
    int src_gap = 0;
    bit src_idle_on = 1'b1;
    int sink_wait = 0;
    int sink_seen = 0;
    bit sink_idle_on = 1'b1;
    int hold_req_cnt = 0;
    int hold_seen = 0;
    int stall_cycles = 0;
    int err_cnt = 0;
    list_op_t          next_op;
    alid_pkg::result_t want;

    // run statistics
    int op_count [8];
    int hit_count = 0;
    int full_refusals = 0;
    int peak_len = 0;
    int cap_writes = 0;

    // capacity as the list sees it: zero acts as one, anything past the store is clipped
    function automatic int cap_limit(logic [alid_pkg::LEN_W-1:0] cap);
        if (cap == 0) return 1;
        if (cap > LIST_DEPTH) return LIST_DEPTH;
        return cap;
    endfunction

    // applies one operation to the behavioral list and returns the result beat it owes
    function automatic alid_pkg::result_t apply_list_op(logic [2:0] mode,
                                                        logic [alid_pkg::POS_W-1:0] pos,
                                                        logic [alid_pkg::VAL_W-1:0] value);
        alid_pkg::result_t res;
        int lim;
        int k;
        res.status = 1'b1;
        res.found_position = '0;
        lim = cap_limit(cap_reg);
        op_count[mode]++;
        case (mode)
            alid_pkg::MODE_INSERT: begin
                if (list_len >= lim) begin
                    full_refusals++;
                end else if (pos <= list_len) begin
                    for (k = list_len; k > pos; k--) list_mem[k] = list_mem[k - 1];
                    list_mem[pos] = value;
                    list_len++;
                    res.status = 1'b0;
                end
            end
            alid_pkg::MODE_DELETE: begin
                if (pos < list_len) begin
                    for (k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
                    list_len--;
                    res.status = 1'b0;
                end
            end
            alid_pkg::MODE_LOCATE: begin
                // first matching position wins
                for (k = 0; k < list_len; k++) begin
                    if (res.status && list_mem[k] == value) begin
                        res.status = 1'b0;
                        res.found_position = alid_pkg::POS_W'(k);
                        hit_count++;
                    end
                end
            end
            alid_pkg::MODE_CHANGE: begin
                if (pos < list_len) begin
                    list_mem[pos] = value;
                    res.status = 1'b0;
                end
            end
            alid_pkg::MODE_CLEAR: begin
                if (list_len != 0) begin
                    list_len = 0;
                    res.status = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (list_len > peak_len) peak_len = list_len;
        res.length = alid_pkg::LEN_W'(list_len);
        return res;
    endfunction

    // queue one operation and follow its effect on the count
    task automatic push_op(logic [2:0] mode, logic [alid_pkg::POS_W-1:0] pos,
                           logic [alid_pkg::VAL_W-1:0] value);
        op_queue.push_back('{mode: mode, pos: pos, value: value});
        case (mode)
            alid_pkg::MODE_INSERT: if (gen_len < gen_lim && pos <= gen_len) gen_len++;
            alid_pkg::MODE_DELETE: if (pos < gen_len) gen_len--;
            alid_pkg::MODE_CLEAR:  gen_len = 0;
            default: begin
            end
        endcase
    endtask

    // mostly a position inside the list, now and then any position
    function automatic logic [alid_pkg::POS_W-1:0] pick_pos(int span);
        if (span <= 0 || $urandom_range(0, 7) == 0)
            return alid_pkg::POS_W'($urandom_range(0, 31));
        if (span > LIST_DEPTH) span = LIST_DEPTH;
        return alid_pkg::POS_W'($urandom_range(0, span - 1));
    endfunction

    // pool values repeat, so locates hit and duplicates show up
    function automatic logic [alid_pkg::VAL_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // sender pauses here until every beat has gone through and come back
    task automatic wait_list_idle();
        while (op_queue.size() != 0 || in_offered != in_taken || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // input driver: one beat at a time, random gap after each beat when idling is on
    always @(negedge aclk) begin
        if (aresetn && in_offered == in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                next_op = op_queue.pop_front();
                s_mode       <= next_op.mode;
                s_position   <= next_op.pos;
                s_item_value <= next_op.value;
                s_valid      <= 1'b1;
                in_offered++;
                src_gap = src_idle_on ? $urandom_range(0, 13) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall after each beat when idling is on, plus the long hold-off on request
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken != sink_seen) begin
                sink_seen = out_taken;
                sink_wait = sink_idle_on ? $urandom_range(0, 13) : 0;
            end
            if (hold_seen != hold_req_cnt) begin
                hold_seen = hold_req_cnt;
                sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: check result beats first, then predict for the beat taken at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                out_taken++;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d pos %0d length %0d",
                           m_status, m_found_position, m_length);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        err_cnt++;
                    end
                    if (m_found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, m_found_position);
                        err_cnt++;
                    end
                    if (m_length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, m_length);
                        err_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                in_taken++;
                expected_results.push_back(apply_list_op(s_mode, s_position, s_item_value));
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int p;
        int k;
        int r;
        int ins_pct;
        int del_pct;
        int loc_pct;
        logic [alid_pkg::LEN_W-1:0] cap;
        op_mix_t mix;

        for (k = 0; k < 8; k++) op_count[k] = 0;
        for (k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty-list refusals, value extremes, bad positions, duplicates,
        // spare codes, clear and clear-when-empty
        push_op(alid_pkg::MODE_CLEAR,  5'd0,  32'h0);
        push_op(alid_pkg::MODE_DELETE, 5'd0,  32'h0);
        push_op(alid_pkg::MODE_CHANGE, 5'd0,  32'h1);
        push_op(alid_pkg::MODE_LOCATE, 5'd0,  32'h0);
        push_op(alid_pkg::MODE_INSERT, 5'd1,  32'h5);              // past the end
        push_op(alid_pkg::MODE_INSERT, 5'd0,  32'h8000_0000);
        push_op(alid_pkg::MODE_INSERT, 5'd1,  32'h7fff_ffff);
        push_op(alid_pkg::MODE_INSERT, 5'd0,  32'h0);
        push_op(alid_pkg::MODE_INSERT, 5'd3,  32'hffff_ffff);      // append at the end
        push_op(alid_pkg::MODE_LOCATE, 5'd31, 32'h7fff_ffff);
        push_op(alid_pkg::MODE_LOCATE, 5'd0,  32'd12345);          // missing value
        push_op(alid_pkg::MODE_CHANGE, 5'd31, 32'h2);
        push_op(alid_pkg::MODE_CHANGE, 5'd0,  32'hffff_ffff);      // duplicate of the tail
        push_op(alid_pkg::MODE_LOCATE, 5'd17, 32'hffff_ffff);      // first copy wins
        push_op(alid_pkg::MODE_DELETE, 5'd4,  32'h0);              // one past the last entry
        push_op(alid_pkg::MODE_DELETE, 5'd1,  32'h0);
        push_op(alid_pkg::MODE_DELETE, 5'd31, 32'hffff_ffff);
        push_op(MODE_SPARE_FIRST, 5'd31, 32'hffff_ffff);
        push_op(MODE_SPARE_FIRST + 3'd1, 5'd0, 32'h8000_0000);
        push_op(MODE_SPARE_LAST, 5'd15, 32'h7fff_ffff);
        push_op(alid_pkg::MODE_INSERT, 5'd31, 32'h3);
        push_op(alid_pkg::MODE_CLEAR,  5'd31, 32'hffff_ffff);
        push_op(alid_pkg::MODE_CLEAR,  5'd0,  32'h0);
        wait_list_idle();

        // random phases: each one at its own capacity, the first few at the extremes,
        // one drops the capacity under a long list so it counts as full
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cap = 6'd32; mix = MIX_GROW;     end
                1: begin cap = 6'd63; mix = MIX_BALANCED; end
                2: begin cap = 6'd5;  mix = MIX_SHRINK;   end
                3: begin cap = 6'd1;  mix = MIX_GROW;     end
                4: begin cap = 6'd0;  mix = MIX_GROW;     end
                5: begin cap = 6'd33; mix = MIX_GROW;     end
                6: begin cap = 6'd2;  mix = MIX_BALANCED; end
                7: begin cap = 6'd31; mix = MIX_GROW;     end
                default: begin
                    cap = alid_pkg::LEN_W'($urandom_range(0, 63));
                    mix = op_mix_t'($urandom_range(0, 2));
                end
            endcase

            // capacity write with the unit idle
            @(negedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= cap;
            cap_reg = cap;
            gen_lim = cap_limit(cap);
            cap_writes++;
            @(negedge aclk);
            cfg_wr_en <= 1'b0;

            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            if (p == CALM_PHASE) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            if (p == HOLD_PHASE) begin
                // receiver stops while the sender streams: the result buffer fills
                src_idle_on = 1'b0;
                hold_req_cnt++;
            end

            case (mix)
                MIX_GROW:     begin ins_pct = 70; del_pct = 8;  loc_pct = 12; end
                MIX_SHRINK:   begin ins_pct = 15; del_pct = 50; loc_pct = 17; end
                default:      begin ins_pct = 38; del_pct = 30; loc_pct = 17; end
            endcase

            for (k = 0; k < PHASE_OPS; k++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    push_op(alid_pkg::MODE_INSERT, pick_pos(gen_len + 1), pick_value(40));
                else if (r < ins_pct + del_pct)
                    push_op(alid_pkg::MODE_DELETE, pick_pos(gen_len), pick_value(40));
                else if (r < ins_pct + del_pct + loc_pct)
                    push_op(alid_pkg::MODE_LOCATE, alid_pkg::POS_W'($urandom_range(0, 31)),
                            pick_value(75));
                else if (r < 97)
                    push_op(alid_pkg::MODE_CHANGE, pick_pos(gen_len), pick_value(40));
                else if (r < 98)
                    push_op(alid_pkg::MODE_CLEAR, alid_pkg::POS_W'($urandom_range(0, 31)),
                            $urandom());
                else
                    push_op(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                            alid_pkg::POS_W'($urandom_range(0, 31)), $urandom());
            end
            wait_list_idle();
        end

        // let any stray result beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            err_cnt++;
        end

        $display("covered %0d beats: %0d inserts (%0d refused as full), %0d deletes, %0d changes",
                 in_taken, op_count[alid_pkg::MODE_INSERT], full_refusals,
                 op_count[alid_pkg::MODE_DELETE], op_count[alid_pkg::MODE_CHANGE]);
        $display("%0d locates (%0d hits), %0d clears, peak length %0d, %0d capacity writes",
                 op_count[alid_pkg::MODE_LOCATE], hit_count, op_count[alid_pkg::MODE_CLEAR],
                 peak_len, cap_writes);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
